// ===== sv/hhma_pkg.sv =====
// ----------------------------------------------------------------------------
// hhma_pkg
// Shared types, codes and constant tables of the harmonic hit-map accumulator.
// ----------------------------------------------------------------------------
package hhma_pkg;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam int unsigned NumLanes  = 3;
  localparam int unsigned NumChains = 6;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] ONE_Q30     = 32'd1073741824;

  typedef enum logic [1:0] {
    CMD_ACCUM     = 2'd0,
    CMD_READ      = 2'd1,
    CMD_READ_ZERO = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [11:0] pixel;
    logic [15:0] angle;
  } entry_t;

  typedef logic [NumChains-1:0][15:0] cs_t;

  typedef struct packed {
    logic [31:0]                count;
    logic [NumChains-1:0][47:0] sum;
  } row_t;

  typedef struct packed {
    logic        start;
    logic [15:0] angle;
  } trig_req_t;

  typedef struct packed {
    logic done;
    cs_t  cs;
  } trig_rsp_t;

  typedef struct packed {
    logic [6:0]  d;
    logic [31:0] m;
    logic [5:0]  s;
  } coef_t;

  // Series term divisor, halved, with its reciprocal and shift.
  function automatic coef_t div_coef(input logic is_sin, input logic [2:0] step);
    coef_t c;
    c = '{d: 7'd1, m: 32'd2147483648, s: 6'd31};
    case ({is_sin, step})
      4'b0_000: c = '{d: 7'd1,   m: 32'd2147483648, s: 6'd31};
      4'b0_001: c = '{d: 7'd6,   m: 32'd2863311530, s: 6'd34};
      4'b0_010: c = '{d: 7'd15,  m: 32'd2290649224, s: 6'd35};
      4'b0_011: c = '{d: 7'd28,  m: 32'd2454267026, s: 6'd36};
      4'b0_100: c = '{d: 7'd45,  m: 32'd3054198966, s: 6'd37};
      4'b0_101: c = '{d: 7'd66,  m: 32'd4164816771, s: 6'd38};
      4'b0_110: c = '{d: 7'd91,  m: 32'd3020636340, s: 6'd38};
      4'b1_000: c = '{d: 7'd3,   m: 32'd2863311530, s: 6'd33};
      4'b1_001: c = '{d: 7'd10,  m: 32'd3435973836, s: 6'd35};
      4'b1_010: c = '{d: 7'd21,  m: 32'd3272356035, s: 6'd36};
      4'b1_011: c = '{d: 7'd36,  m: 32'd3817748707, s: 6'd37};
      4'b1_100: c = '{d: 7'd55,  m: 32'd2498890063, s: 6'd37};
      4'b1_101: c = '{d: 7'd78,  m: 32'd3524075730, s: 6'd38};
      4'b1_110: c = '{d: 7'd105, m: 32'd2617884828, s: 6'd38};
      default:  c = '{d: 7'd1,   m: 32'd2147483648, s: 6'd31};
    endcase
    return c;
  endfunction

endpackage

// ===== sv/harmonic_hit_map_accumulator.sv =====
// ----------------------------------------------------------------------------
// harmonic_hit_map_accumulator
// Sky-map binning of angle samples: per pixel a hit count and harmonic sums.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes a word with operation, pixel and
// angle. An accumulate word adds cos/sin of the angle, twice and four times
// the angle to the pixel and bumps its count; it returns nothing. A pixel at
// its maximum count, or beyond NUM_PIXELS, leaves the store untouched. A read
// word returns one result word (out_valid_o/out_ready_i) with the count and
// six sums; a pixel beyond NUM_PIXELS reads as all zero.
// A two-entry queue separates accepting from executing. An accumulate runs
// 42 series term steps in the back end through a shared four-stage
// multiply/divide pipeline, plus angle setup, drain and write-back. A read
// goes from the store to a read register and on to the result register.
// After reset the store is cleared one pixel per cycle, all NUM_PIXELS pixels,
// with in_ready_o low. A stalled receiver holds the result register; further
// accumulates proceed, a following read waits until the result is taken.
// ----------------------------------------------------------------------------
module harmonic_hit_map_accumulator #(
  parameter int unsigned NUM_PIXELS = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [11:0]        pixel_i,
  input  logic [15:0]        angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        hit_count_o,
  output logic signed [47:0] sum_cos_one_o,
  output logic signed [47:0] sum_sin_one_o,
  output logic signed [47:0] sum_cos_two_o,
  output logic signed [47:0] sum_sin_two_o,
  output logic signed [47:0] sum_cos_four_o,
  output logic signed [47:0] sum_sin_four_o
);
  import hhma_pkg::*;

  logic      clr_busy, q_valid, q_pop;
  entry_t    q_entry;
  trig_req_t trig_req;
  trig_rsp_t trig_rsp;
  row_t      out_row;

  hhma_front #(
    .NUM_PIXELS (NUM_PIXELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .pixel_i     (pixel_i),
    .angle_i     (angle_i),
    .clr_busy_i  (clr_busy),
    .q_valid_o   (q_valid),
    .q_entry_o   (q_entry),
    .q_pop_i     (q_pop)
  );

  hhma_trig u_trig (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (trig_req),
    .rsp_o  (trig_rsp)
  );

  hhma_back #(
    .NUM_PIXELS (NUM_PIXELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_busy_o  (clr_busy),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .trig_req_o  (trig_req),
    .trig_rsp_i  (trig_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_row_o   (out_row)
  );

  assign hit_count_o    = out_row.count;
  assign sum_cos_one_o  = out_row.sum[0];
  assign sum_sin_one_o  = out_row.sum[1];
  assign sum_cos_two_o  = out_row.sum[2];
  assign sum_sin_two_o  = out_row.sum[3];
  assign sum_cos_four_o = out_row.sum[4];
  assign sum_sin_four_o = out_row.sum[5];

endmodule

// ===== sv/hhma_front.sv =====
// ----------------------------------------------------------------------------
// hhma_front
// Input side: accepts words, classifies them and queues the work for the back.
// ----------------------------------------------------------------------------
module hhma_front #(
  parameter int unsigned NUM_PIXELS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [11:0]       pixel_i,
  input  logic [15:0]       angle_i,
  input  logic              clr_busy_i,
  output logic              q_valid_o,
  output hhma_pkg::entry_t  q_entry_o,
  input  logic              q_pop_i
);
  import hhma_pkg::*;

  entry_t     fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       in_range, keep, push;
  entry_t     entry;

  always_comb begin
    in_range    = 32'(pixel_i) < 32'(NUM_PIXELS);
    keep        = (operation_i == OP_READ) || in_range;
    entry.pixel = pixel_i;
    entry.angle = angle_i;
    if (operation_i == OP_READ) begin
      entry.cmd = in_range ? CMD_READ : CMD_READ_ZERO;
    end else begin
      entry.cmd = CMD_ACCUM;
    end
  end

  assign in_ready_o = (cnt_q != 2'd2) && !clr_busy_i;
  assign push       = in_valid_i && in_ready_o && keep;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_entry_o  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, q_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

endmodule

// ===== sv/hhma_trig.sv =====
// ----------------------------------------------------------------------------
// hhma_trig
// Cos and sin of an angle, twice it and four times it, by a truncated series.
// Six series share one four-stage term pipeline in round-robin order.
// ----------------------------------------------------------------------------
module hhma_trig (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hhma_pkg::trig_req_t req_i,
  output hhma_pkg::trig_rsp_t rsp_o
);
  import hhma_pkg::*;

  typedef enum logic [4:0] {
    TS_IDLE  = 5'b00001,
    TS_X2    = 5'b00010,
    TS_RUN   = 5'b00100,
    TS_DRAIN = 5'b01000,
    TS_FIN   = 5'b10000
  } tstate_e;

  localparam logic [2:0] LastChain = 3'd5;
  localparam logic [2:0] LastStep  = 3'd6;

  tstate_e             state_q;
  logic [1:0]          quad_q [NumLanes];
  logic [30:0]         x_q    [NumLanes];
  logic [31:0]         x2_q   [NumLanes];
  logic [31:0]         t_q    [NumChains];
  logic signed [33:0]  acc_q  [NumChains];
  logic [2:0]          ch_q, st_q;

  logic                v1_q, v2_q, v3_q;
  logic [2:0]          ch1_q, ch2_q, ch3_q, st1_q, st2_q, st3_q;
  logic [63:0]         mul1_q, mul2_q;
  logic [31:0]         p2_q, tn3_q;

  cs_t                 cs_q;
  logic                done_q;

  logic [15:0]         b_lane [NumLanes];
  logic [44:0]         xp     [NumLanes];
  logic [61:0]         sq     [NumLanes];
  logic [31:0]         p1;
  coef_t               c1, c2;
  logic [63:0]         qe_full;
  logic [31:0]         qe, tnew;
  logic [38:0]         qd, rem;
  cs_t                 cs_d;
  logic signed [15:0]  cv, sv;

  function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
    logic [30:0] vc;
    logic [31:0] sum;
    if (v[33]) begin
      vc = '0;
    end else if (v > 34'sd1073741824) begin
      vc = ONE_Q30[30:0];
    end else begin
      vc = v[30:0];
    end
    sum = {1'b0, vc} + 32'd16384;
    if (sum[31:15] > 17'd32767) begin
      return 16'sd32767;
    end
    return sum[30:15];
  endfunction

  always_comb begin
    for (int j = 0; j < NumLanes; j++) begin
      b_lane[j] = req_i.angle << j;
      xp[j]     = {31'b0, b_lane[j][13:0]} * {14'b0, HALF_PI_Q30};
      sq[j]     = {31'b0, x_q[j]} * {31'b0, x_q[j]};
    end
  end

  always_comb begin
    p1      = mul1_q[62:31];
    c1      = div_coef(ch1_q[0], st1_q);
    c2      = div_coef(ch2_q[0], st2_q);
    qe_full = mul2_q >> c2.s;
    qe      = qe_full[31:0];
    qd      = {7'b0, qe} * {32'b0, c2.d};
    rem     = {7'b0, p2_q} - qd;
    tnew    = qe + 32'(rem >= {32'b0, c2.d});
  end

  always_comb begin
    for (int j = 0; j < NumLanes; j++) begin
      cv = to_q15(acc_q[2*j]);
      sv = to_q15(acc_q[2*j+1]);
      case (quad_q[j])
        2'd0: begin
          cs_d[2*j]   = cv;
          cs_d[2*j+1] = sv;
        end
        2'd1: begin
          cs_d[2*j]   = -sv;
          cs_d[2*j+1] = cv;
        end
        2'd2: begin
          cs_d[2*j]   = -cv;
          cs_d[2*j+1] = -sv;
        end
        default: begin
          cs_d[2*j]   = sv;
          cs_d[2*j+1] = -cv;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TS_IDLE;
      ch_q    <= '0;
      st_q    <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      v1_q   <= state_q == TS_RUN;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= 1'b0;
      unique case (state_q)
        TS_IDLE: begin
          if (req_i.start) begin
            state_q <= TS_X2;
          end
        end
        TS_X2: begin
          ch_q    <= '0;
          st_q    <= '0;
          state_q <= TS_RUN;
        end
        TS_RUN: begin
          if (ch_q == LastChain) begin
            ch_q <= '0;
            st_q <= st_q + 3'd1;
            if (st_q == LastStep) begin
              state_q <= TS_DRAIN;
            end
          end else begin
            ch_q <= ch_q + 3'd1;
          end
        end
        TS_DRAIN: begin
          if (!v1_q && !v2_q && !v3_q) begin
            state_q <= TS_FIN;
          end
        end
        TS_FIN: begin
          done_q  <= 1'b1;
          state_q <= TS_IDLE;
        end
        default: state_q <= TS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == TS_IDLE && req_i.start) begin
      for (int j = 0; j < NumLanes; j++) begin
        quad_q[j] <= b_lane[j][15:14];
        x_q[j]    <= xp[j][44:14];
      end
    end
    if (state_q == TS_X2) begin
      for (int j = 0; j < NumLanes; j++) begin
        x2_q[j]      <= sq[j][61:30];
        t_q[2*j]     <= ONE_Q30;
        acc_q[2*j]   <= 34'(ONE_Q30);
        t_q[2*j+1]   <= {1'b0, x_q[j]};
        acc_q[2*j+1] <= 34'({1'b0, x_q[j]});
      end
    end
    mul1_q <= {32'b0, t_q[ch_q]} * {32'b0, x2_q[ch_q[2:1]]};
    ch1_q  <= ch_q;
    st1_q  <= st_q;
    mul2_q <= {32'b0, p1} * {32'b0, c1.m};
    p2_q   <= p1;
    ch2_q  <= ch1_q;
    st2_q  <= st1_q;
    tn3_q  <= tnew;
    ch3_q  <= ch2_q;
    st3_q  <= st2_q;
    if (v2_q) begin
      t_q[ch2_q] <= tnew;
    end
    if (v3_q) begin
      if (!st3_q[0]) begin
        acc_q[ch3_q] <= acc_q[ch3_q] - 34'(tn3_q);
      end else begin
        acc_q[ch3_q] <= acc_q[ch3_q] + 34'(tn3_q);
      end
    end
    if (state_q == TS_FIN) begin
      cs_q <= cs_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.cs   = cs_q;

endmodule

// ===== sv/hhma_back.sv =====
// ----------------------------------------------------------------------------
// hhma_back
// Execution side: pixel store, read-modify-write of sums and result register.
// ----------------------------------------------------------------------------
module hhma_back #(
  parameter int unsigned NUM_PIXELS = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  output logic                clr_busy_o,
  input  logic                q_valid_i,
  input  hhma_pkg::entry_t    q_entry_i,
  output logic                q_pop_o,
  output hhma_pkg::trig_req_t trig_req_o,
  input  hhma_pkg::trig_rsp_t trig_rsp_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hhma_pkg::row_t      out_row_o
);
  import hhma_pkg::*;

  localparam int unsigned AW       = $clog2(NUM_PIXELS);
  localparam logic [AW-1:0] LastAddr = AW'(NUM_PIXELS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_ACCUM = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  row_t          mem [NUM_PIXELS];
  row_t          rd_q, out_q, upd_row, wr_row;
  logic [AW-1:0] clr_q, acc_addr_q, rd_addr, wr_addr;
  logic          out_valid_q, rd_en, wr_en, pop, load_zero, load_read;

  always_comb begin
    upd_row.count = rd_q.count + 32'd1;
    for (int i = 0; i < NumChains; i++) begin
      upd_row.sum[i] = rd_q.sum[i] + {{32{trig_rsp_i.cs[i][15]}}, trig_rsp_i.cs[i]};
    end
  end

  always_comb begin
    state_d          = state_q;
    pop              = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = AW'(q_entry_i.pixel);
    wr_en            = 1'b0;
    wr_addr          = acc_addr_q;
    wr_row           = upd_row;
    load_zero        = 1'b0;
    load_read        = 1'b0;
    trig_req_o.start = 1'b0;
    trig_req_o.angle = q_entry_i.angle;
    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_row  = '0;
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_entry_i.cmd)
            CMD_ACCUM: begin
              pop              = 1'b1;
              rd_en            = 1'b1;
              trig_req_o.start = 1'b1;
              state_d          = ST_ACCUM;
            end
            CMD_READ: begin
              if (!out_valid_q) begin
                pop     = 1'b1;
                rd_en   = 1'b1;
                state_d = ST_READ;
              end
            end
            CMD_READ_ZERO: begin
              if (!out_valid_q) begin
                pop       = 1'b1;
                load_zero = 1'b1;
              end
            end
            default: pop = 1'b0;
          endcase
        end
      end
      ST_READ: begin
        load_read = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_ACCUM: begin
        if (trig_rsp_i.done) begin
          wr_en   = rd_q.count != '1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load_zero || load_read) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      acc_addr_q <= rd_addr;
    end
    if (load_zero) begin
      out_q <= '0;
    end else if (load_read) begin
      out_q <= rd_q;
    end
  end

  assign clr_busy_o  = state_q == ST_CLEAR;
  assign q_pop_o     = pop;
  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_q;

endmodule
